>>> hw/rtl/assert_macros.svh
// Assertion macros for the table unit checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/tkvh_pkg.sv
package tkvh_pkg;

    localparam int unsigned MaxSlotsDef = 1024;
    localparam int unsigned KeyBytesDef = 8;
    localparam int unsigned CfgW        = 11;
    localparam int unsigned CfgIdxW     = 1;

    localparam logic [63:0] FnvOffset = 64'd1469598103934665603;
    localparam logic [63:0] FnvPrime  = 64'd1099511628211;

    localparam logic [CfgIdxW-1:0] RegCapacity    = 1'd0;
    localparam logic [CfgIdxW-1:0] RegLinearLimit = 1'd1;

    localparam logic KindLookup = 1'b0;
    localparam logic KindStore  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [63:0] key_bytes;
        logic [3:0]  key_len;
        logic [1:0]  value_type;
        logic [63:0] value_in;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic [63:0] value_out;
    } t_out_item;

endpackage

>>> hw/rtl/typed_key_value_hash_table_unit.sv
// Each access hashes its key bytes (none in linear mode), then probes slots; a full hashed
// table fails without probing. Each byte is one xor, three passes of a shared 32x32
// multiplier and a sum; each further probe is one registered read.
// Accesses: one at a time; busy falls in the cycle after the strobe.
// Reset: capacity MAX_SLOTS, linear limit 8, then a clearing pass over the valid memory with
// busy high; a capacity write starts the same pass. Results cannot be stalled.
module typed_key_value_hash_table_unit #(
    parameter int unsigned MAX_SLOTS = tkvh_pkg::MaxSlotsDef,
    parameter int unsigned KEY_BYTES = tkvh_pkg::KeyBytesDef
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  tkvh_pkg::t_in_item          i_item,
    output logic                        o_result_strobe,
    output tkvh_pkg::t_out_item         o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tkvh_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [tkvh_pkg::CfgW-1:0]   i_cfg_data
);
    import tkvh_pkg::*;

    localparam int unsigned AW = $clog2(MAX_SLOTS);
    localparam int unsigned CW = AW + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HXOR, S_HMUL0, S_HMUL1, S_HMUL2, S_HSUM, S_PSTART,
        S_READ, S_WAIT, S_CHECK, S_DONE
    } t_state;

    t_state           r_state;
    logic [AW-1:0]    r_clr;
    logic [CW-1:0]    r_cap;
    logic [CfgW-1:0]  r_lin;
    logic [CW-1:0]    r_count;
    t_in_item         r_item;
    logic [63:0]      r_key;
    logic [3:0]       r_len;
    logic [3:0]       r_byte;
    logic [63:0]      r_hash;
    logic [63:0]      r_pa, r_pb, r_pc;
    logic [AW-1:0]    r_slot;
    logic [CW-1:0]    r_probes;
    logic             r_linear;
    logic             r_strobe;
    t_out_item        r_res;

    logic             mem_valid [MAX_SLOTS];
    logic [63:0]      mem_key   [MAX_SLOTS];
    logic [3:0]       mem_len   [MAX_SLOTS];
    logic [1:0]       mem_type  [MAX_SLOTS];
    logic [63:0]      mem_value [MAX_SLOTS];
    logic             r_rd_valid;
    logic [63:0]      r_rd_key;
    logic [3:0]       r_rd_len;
    logic [1:0]       r_rd_type;
    logic [63:0]      r_rd_value;

    logic [CW-1:0]    cap_eff;
    logic [AW-1:0]    mask;
    logic [3:0]       len_c;
    logic [63:0]      key_c;
    logic [31:0]      mul_a, mul_b;
    logic [63:0]      mul_p;
    logic             hit;
    logic             wr_en, wr_clr;
    logic [AW-1:0]    wr_addr;

    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CW'(1);
        end else begin
            cap_eff = r_cap;
        end
        mask = AW'(cap_eff - CW'(1));
        if (i_item.key_len > 4'(KEY_BYTES)) begin
            len_c = 4'(KEY_BYTES);
        end else begin
            len_c = i_item.key_len;
        end
        key_c = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < len_c) begin
                key_c[8*i +: 8] = i_item.key_bytes[8*i +: 8];
            end
        end
    end

    // one shared 32x32 multiplier; operand chosen by hash step
    always_comb begin
        unique case (r_state)
            S_HMUL0: begin mul_a = r_hash[31:0];  mul_b = FnvPrime[31:0];  end
            S_HMUL1: begin mul_a = r_hash[63:32]; mul_b = FnvPrime[31:0];  end
            default: begin mul_a = r_hash[31:0];  mul_b = FnvPrime[63:32]; end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    assign hit = !r_rd_valid || (r_rd_len == r_len && r_rd_key == r_key);
    assign wr_clr = (r_state == S_CLEAR);
    assign wr_en  = wr_clr || (r_state == S_CHECK && hit && r_item.kind == KindStore);
    assign wr_addr = wr_clr ? r_clr : r_slot;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_valid[wr_addr] <= !wr_clr;
        end
        if (wr_en && !wr_clr) begin
            mem_key[wr_addr]   <= r_key;
            mem_len[wr_addr]   <= r_len;
            mem_type[wr_addr]  <= r_item.value_type;
            mem_value[wr_addr] <= r_item.value_in;
        end
        r_rd_valid <= mem_valid[r_slot];
        r_rd_key   <= mem_key[r_slot];
        r_rd_len   <= mem_len[r_slot];
        r_rd_type  <= mem_type[r_slot];
        r_rd_value <= mem_value[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_cap    <= CW'(MAX_SLOTS);
            r_lin    <= CfgW'(8);
            r_count  <= '0;
            r_strobe <= 1'b0;
            r_res    <= '0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    RegCapacity: begin
                        if (32'(i_cfg_data) > 32'(MAX_SLOTS)) begin
                            r_cap <= CW'(MAX_SLOTS);
                        end else begin
                            r_cap <= CW'(i_cfg_data);
                        end
                        r_count <= '0;
                        r_clr   <= '0;
                        r_state <= S_CLEAR;
                    end
                    RegLinearLimit: r_lin <= i_cfg_data;
                    default: ;
                endcase
            end else begin
                unique case (r_state)
                    S_CLEAR: begin
                        r_clr <= r_clr + AW'(1);
                        if (r_clr == AW'(MAX_SLOTS - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (start) begin
                            r_item   <= i_item;
                            r_key    <= key_c;
                            r_len    <= len_c;
                            r_byte   <= '0;
                            r_hash   <= FnvOffset;
                            r_linear <= (32'(cap_eff) <= 32'(r_lin));
                            r_state  <= S_HXOR;
                        end
                    end
                    S_HXOR: begin
                        if (r_linear) begin
                            r_state <= S_PSTART;
                        end else if (r_byte == r_len) begin
                            r_state <= S_PSTART;
                        end else begin
                            r_hash  <= r_hash ^ {56'd0, r_key[8*r_byte[2:0] +: 8]};
                            r_state <= S_HMUL0;
                        end
                    end
                    S_HMUL0: begin r_pa <= mul_p; r_state <= S_HMUL1; end
                    S_HMUL1: begin r_pb <= mul_p; r_state <= S_HMUL2; end
                    S_HMUL2: begin r_pc <= mul_p; r_state <= S_HSUM;  end
                    S_HSUM: begin
                        r_hash  <= r_pa + {r_pb[31:0], 32'd0} + {r_pc[31:0], 32'd0};
                        r_byte  <= r_byte + 4'd1;
                        r_state <= S_HXOR;
                    end
                    S_PSTART: begin
                        r_probes <= '0;
                        r_slot   <= r_linear ? '0 : (r_hash[AW-1:0] & mask);
                        if (!r_linear && r_count >= cap_eff) begin
                            r_res    <= '0;
                            r_strobe <= 1'b1;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                    S_READ: r_state <= S_WAIT;
                    S_WAIT: r_state <= S_CHECK;
                    S_CHECK: begin
                        if (hit) begin
                            r_strobe <= 1'b1;
                            r_state  <= S_DONE;
                            if (r_item.kind == KindStore) begin
                                r_res <= '{ok: 1'b1, value_out: 64'd0};
                                if (!r_rd_valid) begin
                                    r_count <= r_count + CW'(1);
                                end
                            end else if (r_rd_valid && r_rd_type == r_item.value_type) begin
                                r_res <= '{ok: 1'b1, value_out: r_rd_value};
                            end else begin
                                r_res <= '0;
                            end
                        end else if (r_probes + CW'(1) >= cap_eff) begin
                            r_res    <= '0;
                            r_strobe <= 1'b1;
                            r_state  <= S_DONE;
                        end else begin
                            r_probes <= r_probes + CW'(1);
                            r_slot   <= r_linear ? r_slot + AW'(1) : ((r_slot + AW'(1)) & mask);
                            r_state  <= S_WAIT;
                        end
                    end
                    S_DONE: r_state <= S_IDLE;
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    assign busy            = (r_state != S_IDLE);
    // a start while idle wins over a register write
    assign o_cfg_ready     = ((r_state == S_IDLE) && !start) || (r_state == S_CLEAR);
    assign o_result_strobe = r_strobe;
    assign o_result        = r_res;
endmodule

>>> hw/rtl/tkvh_checker.sv
module tkvh_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_result_strobe,
    input tkvh_pkg::t_out_item  o_result,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready
);
    import tkvh_pkg::*;
`include "assert_macros.svh"

    `CHK_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy && !(i_cfg_valid && o_cfg_ready), busy, "start did not raise busy")
    `CHK_IMPLY(a_strobe_busy, i_clk, i_rst_n, o_result_strobe, busy, "result while idle")
    `CHK_NEXT(a_strobe_single, i_clk, i_rst_n, o_result_strobe, !o_result_strobe, "double result")
    `CHK_IMPLY(a_fail_zero, i_clk, i_rst_n, o_result_strobe && !o_result.ok, o_result.value_out == 64'd0, "failed access with value")
endmodule

bind typed_key_value_hash_table_unit tkvh_checker u_tkvh_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_result_strobe(o_result_strobe), .o_result(o_result),
    .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready)
);

>>> bench/typed_key_value_hash_table_unit_tb.sv
`timescale 1ns / 1ps

module typed_key_value_hash_table_unit_tb;
    import tkvh_pkg::*;

    localparam int unsigned SLOTS       = 1024;
    localparam int unsigned CYCLE_LIMIT = 10000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in_item    i_item = '0;
    logic        o_result_strobe;
    t_out_item   o_result;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index = '0;
    logic [CfgW-1:0]    i_cfg_data = '0;

    typed_key_value_hash_table_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_item          (i_item),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // table shadow
    logic [CfgW-1:0] cap_reg = 11'd1024;
    logic [CfgW-1:0] lim_reg = 11'd8;
    bit              tbl_valid [SLOTS];
    logic [63:0]     tbl_key   [SLOTS];
    int              tbl_len   [SLOTS];
    logic [1:0]      tbl_type  [SLOTS];
    logic [63:0]     tbl_value [SLOTS];
    int              tbl_entries = 0;

    t_in_item  pending_accesses [$];
    t_out_item expected_results [$];
    int        sender_idle_pct = 0;
    int        mismatches = 0;
    int        cycles = 0;
    int        n_stores = 0, n_lookups = 0, n_hits = 0, n_fails = 0;

    logic [63:0] pool_key [$];
    int          pool_len [$];

    function automatic void clear_shadow();
        for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
        tbl_entries = 0;
    endfunction

    function automatic logic [63:0] fnv_hash(logic [63:0] key, int len);
        logic [63:0] h;
        h = FnvOffset;
        for (int i = 0; i < len; i++) begin
            h = (h ^ {56'd0, key[8*i +: 8]}) * FnvPrime;
        end
        return h;
    endfunction

    function automatic bit slot_fits(int idx, logic [63:0] key, int len);
        if (!tbl_valid[idx]) return 1'b1;
        return tbl_len[idx] == len && tbl_key[idx] == key;
    endfunction

    function automatic t_out_item predict_access(t_in_item it);
        int          len, cap, slot, h;
        logic [63:0] key;
        t_out_item   r;
        r = '0;
        len = it.key_len;
        if (len > 8) len = 8;
        key = it.key_bytes;
        if (len < 8) key &= (64'd1 << (8 * len)) - 64'd1;
        cap = (cap_reg == 0) ? 1 : ((cap_reg > SLOTS) ? SLOTS : cap_reg);
        slot = -1;
        if (cap <= lim_reg) begin
            for (int i = 0; i < cap; i++) begin
                if (slot_fits(i, key, len)) begin
                    slot = i;
                    break;
                end
            end
        end else if (tbl_entries < cap) begin
            h = int'(fnv_hash(key, len) & 64'(cap - 1));
            for (int i = 0; i < cap; i++) begin
                if (slot_fits(h, key, len)) begin
                    slot = h;
                    break;
                end
                h = (h + 1) & (cap - 1);
            end
        end
        if (it.kind == KindStore) begin
            n_stores++;
        end else begin
            n_lookups++;
        end
        if (slot < 0) begin
            n_fails++;
            return r;
        end
        if (it.kind == KindStore) begin
            if (!tbl_valid[slot]) tbl_entries++;
            tbl_valid[slot] = 1'b1;
            tbl_key[slot]   = key;
            tbl_len[slot]   = len;
            tbl_type[slot]  = it.value_type;
            tbl_value[slot] = it.value_in;
            r.ok = 1'b1;
        end else if (tbl_valid[slot] && tbl_type[slot] == it.value_type) begin
            r.ok = 1'b1;
            r.value_out = tbl_value[slot];
            n_hits++;
        end
        return r;
    endfunction

    function automatic t_in_item make_access(logic kind, logic [63:0] key, int len,
                                             logic [1:0] vt, logic [63:0] val);
        t_in_item it;
        it.kind       = kind;
        it.key_bytes  = key;
        it.key_len    = len[3:0];
        it.value_type = vt;
        it.value_in   = val;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // driver: start held until the transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) expected_results.push_back(predict_access(i_item));
            if (!start || !busy) begin
                if (pending_accesses.size() > 0 &&
                        $urandom_range(0, 99) >= sender_idle_pct) begin
                    i_item <= pending_accesses.pop_front();
                    start  <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result: ok=%0b value=%h",
                                               o_result.ok, o_result.value_out);
            end else begin
                t_out_item e;
                e = expected_results.pop_front();
                if (e.ok !== o_result.ok || e.value_out !== o_result.value_out) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected ok=%0b value=%h, got ok=%0b value=%h",
                                 e.ok, e.value_out, o_result.ok, o_result.value_out);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic drain();
        while (pending_accesses.size() > 0 || start || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == RegCapacity) begin
            cap_reg = data;
            clear_shadow();
        end else begin
            lim_reg = data;
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic build_pool(int n);
        logic [63:0] k;
        int          len, r;
        pool_key.delete();
        pool_len.delete();
        for (int p = 0; p < n; p++) begin
            r = $urandom_range(0, 15);
            len = (r < 12) ? $urandom_range(1, 8) : ((r < 14) ? 0 : $urandom_range(9, 15));
            for (int b = 0; b < 8; b++)
                k[8*b +: 8] = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            pool_key.push_back(k);
            pool_len.push_back(len);
        end
    endtask

    task automatic queue_random(int n);
        logic [63:0] k, junk;
        int          len, p;
        for (int j = 0; j < n; j++) begin
            if ($urandom_range(0, 9) == 0) begin
                k = rand64();
                len = $urandom_range(0, 15);
            end else begin
                p = $urandom_range(0, pool_key.size() - 1);
                k = pool_key[p];
                len = pool_len[p];
                junk = rand64();
                if (len < 8) k = (k & ((64'd1 << (8 * len)) - 1)) |
                                 (junk & ~((64'd1 << (8 * len)) - 1));
            end
            pending_accesses.push_back(make_access($urandom_range(0, 1) ? KindStore : KindLookup,
                k, len, 2'($urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(0, 3)),
                rand64()));
        end
    endtask

    task automatic run_phase(int cap, int lim, int n, int pool, int idle);
        drain();
        write_reg(RegCapacity, cap[CfgW-1:0]);
        write_reg(RegLinearLimit, lim[CfgW-1:0]);
        sender_idle_pct = idle;
        build_pool(pool);
        queue_random(n);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        clear_shadow();
        sender_idle_pct = 30;

        // directed, reset settings (hashed)
        pending_accesses.push_back(make_access(KindStore, 64'd0, 0, 2'd0, 64'd0));
        pending_accesses.push_back(make_access(KindLookup, 64'hDEAD, 0, 2'd0, 64'd0));
        pending_accesses.push_back(make_access(KindStore, '1, 8, 2'd3, '1));
        pending_accesses.push_back(make_access(KindLookup, '1, 8, 2'd3, 64'd0));
        pending_accesses.push_back(make_access(KindLookup, '1, 8, 2'd2, 64'd0));
        pending_accesses.push_back(make_access(KindStore, 64'h41_00_42, 3, 2'd1, 64'h1234));
        pending_accesses.push_back(make_access(KindLookup, 64'h42, 1, 2'd1, 64'd0));
        pending_accesses.push_back(make_access(KindLookup, 64'hFFFF_FFFF_FF41_0042, 3, 2'd1,
                                               64'd0));
        pending_accesses.push_back(make_access(KindStore, 64'h0102_0304_0506_0708, 15, 2'd2,
                                               64'h8000_0000_0000_0000));
        pending_accesses.push_back(make_access(KindLookup, 64'h0102_0304_0506_0708, 8, 2'd2,
                                               64'd0));
        pending_accesses.push_back(make_access(KindStore, 64'h41_00_42, 3, 2'd0, 64'h5555));
        pending_accesses.push_back(make_access(KindLookup, 64'h41_00_42, 3, 2'd0, 64'd0));
        pending_accesses.push_back(make_access(KindLookup, 64'h41_00_42, 3, 2'd1, 64'd0));
        pending_accesses.push_back(make_access(KindLookup, 64'h7777, 2, 2'd0, 64'd0));

        // zero capacity acts as one slot: second key fails on a full table
        run_phase(0, 0, 20, 3, 30);
        pending_accesses.push_front(make_access(KindLookup, 64'h62, 1, 2'd0, 64'd0));
        pending_accesses.push_front(make_access(KindLookup, 64'h61, 1, 2'd0, 64'd0));
        pending_accesses.push_front(make_access(KindStore, 64'h62, 1, 2'd0, 64'd9));
        pending_accesses.push_front(make_access(KindStore, 64'h61, 1, 2'd0, 64'd7));

        run_phase(4, 8, 120, 8, 30);
        run_phase(8, 0, 150, 16, 30);
        run_phase(6, 0, 130, 12, 74);
        run_phase(2047, 2047, 120, 24, 74);
        run_phase(1024, 8, 250, 200, 0);
        run_phase(16, 1024, 160, 30, 0);
        drain();

        $display("Covered %0d stores and %0d lookups (%0d hits, %0d failed accesses)",
                 n_stores, n_lookups, n_hits, n_fails);
        $display("over linear, hashed, non-power-of-two, single-slot and clamped capacities");
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
